>>> sv/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared sizes, command codes, sequencer states and the fixed-point scaling
// helper for the sorted table bound search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int TABLE_DEPTH   = 64;
  localparam int VALUE_WIDTH   = 32;
  localparam int FRACTION_BITS = 8;

  // fixed field widths of the streams
  localparam int CMD_W         = 3;
  localparam int VALUE_FIELD_W = 32;
  localparam int TARGET_W      = 40;

  localparam int ADDR_W   = $clog2(TABLE_DEPTH);
  localparam int COUNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int INDEX_W  = ADDR_W + 1;
  localparam int SCALED_W = VALUE_WIDTH + FRACTION_BITS;
  localparam int CMP_W    = (SCALED_W > TARGET_W) ? SCALED_W : TARGET_W;

  localparam int IN_DATA_W  = ((VALUE_FIELD_W + TARGET_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((INDEX_W + 7) / 8) * 8;

  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_CLEAR       = cmd_t'(0);
  localparam cmd_t CMD_INSERT      = cmd_t'(1);
  localparam cmd_t CMD_BELOW       = cmd_t'(2);
  localparam cmd_t CMD_FIRST_EQUAL = cmd_t'(3);
  localparam cmd_t CMD_LAST_EQUAL  = cmd_t'(4);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CHK,
    ST_INS_PUT,
    ST_SRCH_ISSUE,
    ST_SRCH_CHK,
    ST_EQ_ISSUE,
    ST_EQ_CHK,
    ST_FIN
  } state_t;

  // entry v as v * 2^FRACTION_BITS, sign-extended to the compare width
  function automatic logic signed [CMP_W-1:0] scale_value(
    input logic signed [VALUE_WIDTH-1:0] v
  );
    return CMP_W'(v) <<< FRACTION_BITS;
  endfunction

endpackage

>>> sv/stbs_ram.sv
// ----------------------------------------------------------------------------
// stbs_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/sorted_table_bound_search.sv
// ----------------------------------------------------------------------------
// sorted_table_bound_search
// Clear and unused commands go straight to the result; insert moves each larger
// entry up one place, from the end of the table down, then writes the value;
// queries run a binary search over the filled entries, and the equal commands
// then scan forward over the entries equal to the target, up to the table end.
// One command at a time: in_tready is high only while idle; RAM read sets pace.
// Reset (rst_n low, synchronous) empties the table; RAM contents are kept.
// ----------------------------------------------------------------------------
module sorted_table_bound_search (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0] value, [71:32] target_fixed
  input  logic [stbs_pkg::IN_DATA_W-1:0]  in_tdata,
  // [2:0] command
  input  logic [stbs_pkg::CMD_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [6:0] index, [7] zero
  output logic [stbs_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] status
  output logic [0:0]                      out_tuser
);

  import stbs_pkg::*;

  state_t                     state_r, state_nxt;
  cmd_t                       cmd_r, cmd_nxt;
  logic signed [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic signed [TARGET_W-1:0] tgt_r, tgt_nxt;
  logic [COUNT_W-1:0]         count_r, count_nxt;
  logic signed [INDEX_W-1:0]  lo_r, lo_nxt;
  logic signed [INDEX_W-1:0]  hi_r, hi_nxt;
  logic [ADDR_W-1:0]          mid_r, mid_nxt;
  logic [ADDR_W-1:0]          pos_r, pos_nxt;
  logic [INDEX_W-1:0]         res_idx_r, res_idx_nxt;
  logic                       res_st_r, res_st_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [INDEX_W-1:0]         out_idx_r, out_idx_nxt;
  logic                       out_st_r, out_st_nxt;

  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_waddr;
  logic [VALUE_WIDTH-1:0]     ram_wdata;
  logic [ADDR_W-1:0]          ram_raddr;
  logic [VALUE_WIDTH-1:0]     ram_rdata;

  logic signed [CMP_W-1:0]    cmp_lhs, cmp_rhs;
  logic                       cmp_lt, cmp_eq;

  logic                       in_xfer;
  logic signed [INDEX_W:0]    cnt_s, cnt_m1, span, mid_sum, lo_inc;
  logic [ADDR_W-1:0]          mid_calc, pos_m1, pos_m2;
  logic signed [INDEX_W-1:0]  mid_s;

  stbs_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared compare unit: insert checks val < entry, queries check entry vs target
  always_comb begin
    if (state_r == ST_INS_CHK) begin
      cmp_lhs = scale_value(val_r);
      cmp_rhs = scale_value(signed'(ram_rdata));
    end else begin
      cmp_lhs = scale_value(signed'(ram_rdata));
      cmp_rhs = CMP_W'(tgt_r);
    end
    cmp_lt = cmp_lhs < cmp_rhs;
    cmp_eq = cmp_lhs == cmp_rhs;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_idx_r);
  assign out_tuser  = out_st_r;

  always_comb begin
    cnt_s    = signed'((INDEX_W+1)'(count_r));
    cnt_m1   = cnt_s - (INDEX_W+1)'(1);
    span     = (INDEX_W+1)'(hi_r) - (INDEX_W+1)'(lo_r) + (INDEX_W+1)'(1);
    mid_sum  = (INDEX_W+1)'(lo_r) + (span >>> 1);
    mid_calc = mid_sum[ADDR_W-1:0];
    mid_s    = signed'({1'b0, mid_r});
    lo_inc   = (INDEX_W+1)'(lo_r) + (INDEX_W+1)'(1);
    pos_m1   = pos_r - ADDR_W'(1);
    pos_m2   = pos_m1 - ADDR_W'(1);
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    val_nxt       = val_r;
    tgt_nxt       = tgt_r;
    count_nxt     = count_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    pos_nxt       = pos_r;
    res_idx_nxt   = res_idx_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_idx_nxt   = out_idx_r;
    out_st_nxt    = out_st_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = val_r;
    ram_raddr     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd_nxt     = in_tuser;
          val_nxt     = signed'(in_tdata[VALUE_WIDTH-1:0]);
          tgt_nxt     = signed'(in_tdata[VALUE_FIELD_W +: TARGET_W]);
          res_idx_nxt = '0;
          res_st_nxt  = 1'b0;
          lo_nxt      = '1;
          hi_nxt      = signed'(cnt_m1[INDEX_W-1:0]);
          pos_nxt     = count_r[ADDR_W-1:0];
          priority if (in_tuser == CMD_CLEAR) begin
            count_nxt = '0;
            state_nxt = ST_FIN;
          end else if (in_tuser == CMD_INSERT) begin
            priority if (count_r >= COUNT_W'(TABLE_DEPTH)) begin
              res_idx_nxt = '1;
              res_st_nxt  = 1'b1;
              state_nxt   = ST_FIN;
            end else if (count_r == '0) begin
              state_nxt = ST_INS_PUT;
            end else begin
              ram_raddr = count_r[ADDR_W-1:0] - ADDR_W'(1);
              state_nxt = ST_INS_CHK;
            end
          end else if (in_tuser == CMD_BELOW || in_tuser == CMD_FIRST_EQUAL ||
                       in_tuser == CMD_LAST_EQUAL) begin
            state_nxt = ST_SRCH_ISSUE;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end

      // entry at pos-1 is on the read port
      ST_INS_CHK: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        if (cmp_lt) begin
          ram_wdata = ram_rdata;
          pos_nxt   = pos_m1;
          if (pos_m1 == '0) begin
            state_nxt = ST_INS_PUT;
          end else begin
            ram_raddr = pos_m2;
          end
        end else begin
          ram_wdata   = val_r;
          count_nxt   = count_r + COUNT_W'(1);
          res_idx_nxt = INDEX_W'(pos_r);
          state_nxt   = ST_FIN;
        end
      end

      ST_INS_PUT: begin
        ram_we      = 1'b1;
        ram_waddr   = pos_r;
        ram_wdata   = val_r;
        count_nxt   = count_r + COUNT_W'(1);
        res_idx_nxt = INDEX_W'(pos_r);
        state_nxt   = ST_FIN;
      end

      ST_SRCH_ISSUE: begin
        priority if (lo_r < hi_r) begin
          mid_nxt   = mid_calc;
          ram_raddr = mid_calc;
          state_nxt = ST_SRCH_CHK;
        end else if (cmd_r == CMD_BELOW) begin
          res_idx_nxt = lo_r;
          state_nxt   = ST_FIN;
        end else begin
          state_nxt = ST_EQ_ISSUE;
        end
      end

      ST_SRCH_CHK: begin
        if (cmp_lt) begin
          lo_nxt = mid_s;
        end else begin
          hi_nxt = mid_s - INDEX_W'(1);
        end
        state_nxt = ST_SRCH_ISSUE;
      end

      ST_EQ_ISSUE: begin
        if (lo_inc < cnt_s) begin
          ram_raddr = lo_inc[ADDR_W-1:0];
          state_nxt = ST_EQ_CHK;
        end else begin
          res_idx_nxt = lo_r;
          state_nxt   = ST_FIN;
        end
      end

      ST_EQ_CHK: begin
        if (cmp_eq) begin
          lo_nxt = signed'(lo_inc[INDEX_W-1:0]);
          if (cmd_r == CMD_FIRST_EQUAL) begin
            res_idx_nxt = lo_inc[INDEX_W-1:0];
            state_nxt   = ST_FIN;
          end else begin
            state_nxt = ST_EQ_ISSUE;
          end
        end else begin
          res_idx_nxt = lo_r;
          state_nxt   = ST_FIN;
        end
      end

      // hand the result to the output register once it is free
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = res_idx_r;
          out_st_nxt    = res_st_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    val_r     <= val_nxt;
    tgt_r     <= tgt_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    pos_r     <= pos_nxt;
    res_idx_r <= res_idx_nxt;
    res_st_r  <= res_st_nxt;
    out_idx_r <= out_idx_nxt;
    out_st_r  <= out_st_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == '0) || (count_r == $past(count_r) + COUNT_W'(1)))
    else $error("entry count moved by more than one insert");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (ram_waddr <= count_r) && (state_r == ST_INS_CHK || state_r == ST_INS_PUT))
    else $error("table write outside the filled range");

  a_mid_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRCH_CHK) |-> (mid_s > lo_r) && (mid_s <= hi_r))
    else $error("probe outside the search window");

  a_full_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r) |-> (&out_idx_r))
    else $error("dropped insert without index of minus one");
`endif

endmodule
